// ----- rtl/ims_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ims_pkg;

	// lattice geometry
	localparam int MAX_SIDE    = 256;
	localparam int SIDE_LEN_W  = 9;
	localparam int SIDE_W      = ($clog2(MAX_SIDE + 1) > SIDE_LEN_W) ?
	                             $clog2(MAX_SIDE + 1) : SIDE_LEN_W;
	localparam int VOL_W       = 2 * SIDE_W;
	localparam int SITE_W      = 16;
	localparam int UNI_W       = 32;

	// spin memory: one bit per site, packed into words
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int WORD_W      = (STORE_DEPTH < 64) ? STORE_DEPTH : 64;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int MEM_ROWS    = STORE_DEPTH / WORD_W;
	localparam int ROW_W       = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;

	// column divider: quotient bits retired per cycle
	localparam int DIV_QW      = $clog2(MAX_SIDE);
	localparam int DIV_STEP    = 4;
	localparam int DIV_GROUPS  = (DIV_QW + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_QP      = DIV_GROUPS * DIV_STEP;
	localparam int DIV_CW      = (SIDE_W + DIV_QP > SITE_W) ? SIDE_W + DIV_QP : SITE_W;
	localparam int DIV_GRP_W   = $clog2(DIV_GROUPS + 1);

	// arithmetic widths
	localparam int J_W         = 16;
	localparam int JS_W        = 19;
	localparam int DE_W        = 20;
	localparam int EACC_W      = 48;
	localparam int MAG_W       = 18;
	localparam int CNT_W       = 3;
	localparam int THR_W       = 64;

	// register bus
	localparam int PADDR_W     = 6;
	localparam int PDATA_W     = 64;

	typedef enum logic [2:0] {
		REG_THR_M4   = 3'd0,
		REG_THR_M2   = 3'd1,
		REG_THR_ZERO = 3'd2,
		REG_THR_P2   = 3'd3,
		REG_THR_P4   = 3'd4,
		REG_COUPLING = 3'd5,
		REG_FIELD    = 3'd6,
		REG_SIDE     = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_DIV,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_EVAL,
		ST_WB
	} ims_state_t;

	typedef struct packed {
		logic              start;
		logic [SITE_W-1:0] dividend;
		logic [SIDE_W-1:0] divisor;
	} colpos_req_t;

	typedef struct packed {
		logic done;
		logic col_first;
		logic col_last;
	} colpos_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ising_metropolis_spin_flip.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                Payload
// --------  -----------------------  ----------------------------------------------
// in        in_valid / in_ready      site, uniform
// out       out_valid / out_ready    accepted, new_spin, energy_delta, energy_change,
//                                    mag_change, site_error
// cfg       psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// A word is taken only in idle, so the next word waits until the last one has
// left write-back; a valid site passes the column divider and five spin reads
// over the memory's two read ports, a bad site goes straight to write-back.
// After reset the spin memory is set to all +1, row by row, with in_ready low;
// register writes are taken during the pass.
// A result waiting in the output register holds the next word at write-back.
module ising_metropolis_spin_flip (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ims_pkg::SITE_W-1:0]           site,
	input  logic [ims_pkg::UNI_W-1:0]            uniform,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 accepted,
	output logic                                 new_spin,
	output logic signed [ims_pkg::DE_W-1:0]      energy_delta,
	output logic signed [ims_pkg::EACC_W-1:0]    energy_change,
	output logic signed [ims_pkg::MAG_W-1:0]     mag_change,
	output logic                                 site_error,
	// register port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ims_pkg::PADDR_W-1:0]          paddr,
	input  logic [ims_pkg::PDATA_W-1:0]          pwdata,
	output logic [ims_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready
);
	import ims_pkg::*;

	// registers
	logic [THR_W-1:0]      thr_m4_q, thr_m2_q, thr_zero_q, thr_p2_q, thr_p4_q;
	logic signed [J_W-1:0] coupling_q;
	logic signed [J_W-1:0] field_q;
	logic [SIDE_LEN_W-1:0] side_q;
	cfg_reg_t              reg_sel;
	logic                  cfg_wr;

	// control
	ims_state_t            state_q, state_next;
	logic [ROW_W-1:0]      clr_q;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  out_load;
	logic                  clr_step;
	logic                  div_start;

	// datapath
	logic [SIDE_W-1:0]     side_ext, side_eff;
	logic [VOL_W-1:0]      vol_q;
	logic [SITE_W-1:0]     site_q;
	logic [UNI_W-1:0]      uniform_q;
	logic                  bad_cmp, bad_q;
	logic [VOL_W-1:0]      site_v, l_v;
	logic [VOL_W-1:0]      nb_right, nb_up, nb_left, nb_down;
	logic [ADDR_W-1:0]     addr_a, addr_b;
	logic [WORD_W-1:0]     rd_a_s1, rd_b_s1;
	logic [BIT_W-1:0]      sel_a_s1, sel_b_s1;
	logic [WORD_W-1:0]     word_q;
	logic                  spin_q;
	logic [2:0]            nbit_q;
	logic                  nbit_down;
	logic [CNT_W-1:0]      nb_cnt;
	logic signed [JS_W-1:0] j_ext, jsum, tsum;
	logic signed [DE_W-1:0] twice_t, de;
	logic [THR_W-1:0]      thr_pair;
	logic [UNI_W-1:0]      thr_sel;
	logic                  acc_cmb;
	logic signed [DE_W-1:0] de_q;
	logic                  acc_q;

	// spin memory
	logic [WORD_W-1:0]     spin_mem [MEM_ROWS];
	logic                  mem_wen;
	logic [ROW_W-1:0]      mem_waddr;
	logic [WORD_W-1:0]     mem_wdata;
	logic [ROW_W-1:0]      raddr_a, raddr_b;

	// accumulators and output word
	logic signed [EACC_W-1:0] energy_acc_q;
	logic signed [MAG_W-1:0]  mag_acc_q;
	logic                  accepted_q, new_spin_q, site_error_q;
	logic signed [DE_W-1:0] energy_delta_q;

	colpos_req_t           div_req;
	colpos_rsp_t           div_rsp;

	// ---------------------------------------------------------------
	// register port
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:3]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_m4_q   <= '0;
			thr_m2_q   <= '0;
			thr_zero_q <= '0;
			thr_p2_q   <= '0;
			thr_p4_q   <= '0;
			coupling_q <= J_W'(256);
			field_q    <= '0;
			side_q     <= SIDE_LEN_W'(16);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_THR_M4:   thr_m4_q   <= pwdata;
				REG_THR_M2:   thr_m2_q   <= pwdata;
				REG_THR_ZERO: thr_zero_q <= pwdata;
				REG_THR_P2:   thr_p2_q   <= pwdata;
				REG_THR_P4:   thr_p4_q   <= pwdata;
				REG_COUPLING: coupling_q <= pwdata[J_W-1:0];
				REG_FIELD:    field_q    <= pwdata[J_W-1:0];
				REG_SIDE:     side_q     <= pwdata[SIDE_LEN_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_sel)
			REG_THR_M4:   prdata = thr_m4_q;
			REG_THR_M2:   prdata = thr_m2_q;
			REG_THR_ZERO: prdata = thr_zero_q;
			REG_THR_P2:   prdata = thr_p2_q;
			REG_THR_P4:   prdata = thr_p4_q;
			REG_COUPLING: prdata = PDATA_W'(unsigned'(coupling_q));
			REG_FIELD:    prdata = PDATA_W'(unsigned'(field_q));
			REG_SIDE:     prdata = PDATA_W'(side_q);
		endcase
	end

	// ---------------------------------------------------------------
	// side in use and lattice volume
	assign side_ext = SIDE_W'(side_q);
	assign side_eff = (side_ext > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_ext;

	always_ff @(posedge clk) begin
		vol_q <= VOL_W'(side_eff) * VOL_W'(side_eff);
	end

	// column divider
	assign div_req = '{start: div_start, dividend: site, divisor: side_eff};

	ims_colpos u_colpos (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// wrapped neighbour addresses
	assign site_v   = VOL_W'(site_q);
	assign l_v      = VOL_W'(side_eff);
	assign bad_cmp  = (site_v >= vol_q);
	assign nb_right = div_rsp.col_last ? site_v + VOL_W'(1) - l_v : site_v + VOL_W'(1);
	assign nb_up    = (site_v >= l_v) ? site_v - l_v : site_v + vol_q - l_v;
	assign nb_left  = div_rsp.col_first ? site_v + l_v - VOL_W'(1) : site_v - VOL_W'(1);
	assign nb_down  = ((site_v + l_v) >= vol_q) ? site_v + l_v - vol_q : site_v + l_v;

	// ---------------------------------------------------------------
	// sequencer: next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLR:  if (clr_q == ROW_W'(MEM_ROWS - 1)) state_next = ST_IDLE;
			ST_IDLE: if (in_valid) state_next = ST_DIV;
			ST_DIV: begin
				if (bad_cmp) begin
					state_next = ST_WB;
				end else if (div_rsp.done) begin
					state_next = ST_RD0;
				end
			end
			ST_RD0:  state_next = ST_RD1;
			ST_RD1:  state_next = ST_RD2;
			ST_RD2:  state_next = ST_EVAL;
			ST_EVAL: state_next = ST_WB;
			ST_WB:   if (out_free) state_next = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		in_ready      = 1'b0;
		div_start     = 1'b0;
		clr_step      = 1'b0;
		out_load      = 1'b0;
		mem_wen       = 1'b0;
		mem_waddr     = ROW_W'(site_q >> BIT_W);
		mem_wdata     = word_q ^ (WORD_W'(1) << site_q[BIT_W-1:0]);
		addr_a        = site_q[ADDR_W-1:0];
		addr_b        = nb_right[ADDR_W-1:0];
		unique case (state_q)
			ST_CLR: begin
				clr_step  = 1'b1;
				mem_wen   = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '1;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid;
			end
			ST_RD1: begin
				addr_a = nb_up[ADDR_W-1:0];
				addr_b = nb_left[ADDR_W-1:0];
			end
			ST_RD2: begin
				addr_a = nb_down[ADDR_W-1:0];
			end
			ST_WB: begin
				out_load = out_free;
				mem_wen  = out_free && !bad_q && acc_q;
			end
			default: ;
		endcase
	end

	assign raddr_a = ROW_W'(addr_a >> BIT_W);
	assign raddr_b = ROW_W'(addr_b >> BIT_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
		end else begin
			state_q <= state_next;
			if (clr_step) begin
				clr_q <= clr_q + ROW_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// spin memory, one write and two read ports
	always_ff @(posedge clk) begin
		if (mem_wen) begin
			spin_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_s1  <= spin_mem[raddr_a];
		rd_b_s1  <= spin_mem[raddr_b];
		sel_a_s1 <= addr_a[BIT_W-1:0];
		sel_b_s1 <= addr_b[BIT_W-1:0];
	end

	// ---------------------------------------------------------------
	// energy of the flip and acceptance test
	assign nbit_down = rd_a_s1[sel_a_s1];
	assign nb_cnt    = CNT_W'(nbit_q[0]) + CNT_W'(nbit_q[1]) + CNT_W'(nbit_q[2])
	                 + CNT_W'(nbit_down);
	assign j_ext     = JS_W'(coupling_q);

	// J times neighbour sum, sum = 2*count - 4
	always_comb begin
		unique case (nb_cnt)
			CNT_W'(0): begin
				jsum     = -(j_ext <<< 2);
				thr_pair = thr_m4_q;
			end
			CNT_W'(1): begin
				jsum     = -(j_ext <<< 1);
				thr_pair = thr_m2_q;
			end
			CNT_W'(2): begin
				jsum     = '0;
				thr_pair = thr_zero_q;
			end
			CNT_W'(3): begin
				jsum     = j_ext <<< 1;
				thr_pair = thr_p2_q;
			end
			CNT_W'(4): begin
				jsum     = j_ext <<< 2;
				thr_pair = thr_p4_q;
			end
			default: begin
				jsum     = '0;
				thr_pair = '0;
			end
		endcase
	end

	assign tsum    = jsum + JS_W'(field_q);
	assign twice_t = DE_W'(tsum) <<< 1;
	assign de      = spin_q ? twice_t : -twice_t;
	assign thr_sel = spin_q ? thr_pair[THR_W-1:UNI_W] : thr_pair[UNI_W-1:0];
	assign acc_cmb = de[DE_W-1] || (uniform_q < thr_sel);

	// item and read-back capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			site_q    <= site;
			uniform_q <= uniform;
		end
		if (state_q == ST_DIV) begin
			bad_q <= bad_cmp;
		end
		if (state_q == ST_RD1) begin
			word_q    <= rd_a_s1;
			spin_q    <= rd_a_s1[sel_a_s1];
			nbit_q[0] <= rd_b_s1[sel_b_s1];
		end
		if (state_q == ST_RD2) begin
			nbit_q[1] <= rd_a_s1[sel_a_s1];
			nbit_q[2] <= rd_b_s1[sel_b_s1];
		end
		if (state_q == ST_EVAL) begin
			de_q  <= de;
			acc_q <= acc_cmb;
		end
	end

	// ---------------------------------------------------------------
	// result word
	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted_q     <= !bad_q && acc_q;
			new_spin_q     <= !bad_q && (spin_q ^ acc_q);
			energy_delta_q <= bad_q ? '0 : de_q;
			site_error_q   <= bad_q;
		end
	end

	// running totals and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			energy_acc_q <= '0;
			mag_acc_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load && !bad_q && acc_q) begin
				energy_acc_q <= energy_acc_q + EACC_W'(de_q);
				mag_acc_q    <= spin_q ? mag_acc_q - MAG_W'(2) : mag_acc_q + MAG_W'(2);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign new_spin      = new_spin_q;
	assign energy_delta  = energy_delta_q;
	assign energy_change = energy_acc_q;
	assign mag_change    = mag_acc_q;
	assign site_error    = site_error_q;

endmodule

`default_nettype wire

// ----- rtl/ims_colpos.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Column position of a site: restoring division of the site index by the
// side, DIV_STEP quotient bits a cycle. Only the remainder is kept; the
// caller needs to know whether the site sits in the first or last column.
module ims_colpos (
	input  logic                clk,
	input  logic                arst_n,
	input  ims_pkg::colpos_req_t req,
	output ims_pkg::colpos_rsp_t rsp
);
	import ims_pkg::*;

	logic [DIV_CW-1:0]    rem_q;
	logic [DIV_CW-1:0]    dvs_q;
	logic [DIV_CW-1:0]    rem_next;
	logic [SIDE_W-1:0]    l_q;
	logic [DIV_GRP_W-1:0] grp_q;

	// one group of compare-subtract steps
	always_comb begin
		rem_next = rem_q;
		for (int j = DIV_STEP - 1; j >= 0; j--) begin
			if (rem_next >= (dvs_q << j)) begin
				rem_next = rem_next - (dvs_q << j);
			end
		end
	end

	// group counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (req.start) begin
			grp_q <= DIV_GRP_W'(DIV_GROUPS);
		end else if (grp_q != '0) begin
			grp_q <= grp_q - DIV_GRP_W'(1);
		end
	end

	// remainder and shifted divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIV_CW'(req.dividend);
			dvs_q <= DIV_CW'(req.divisor) << (DIV_QP - DIV_STEP);
			l_q   <= req.divisor;
		end else if (grp_q != '0) begin
			rem_q <= rem_next;
			dvs_q <= dvs_q >> DIV_STEP;
		end
	end

	assign rsp.done      = (grp_q == '0);
	assign rsp.col_first = (rem_q == '0);
	assign rsp.col_last  = ((rem_q + DIV_CW'(1)) == DIV_CW'(l_q));

endmodule

`default_nettype wire

// ----- tb/tb_ising_metropolis_spin_flip.sv -----
`timescale 1ns / 1ps

module tb_ising_metropolis_spin_flip;
	import ims_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          MAX_PRINTS  = 50;

	typedef struct packed {
		logic [SITE_W-1:0] site;
		logic [UNI_W-1:0]  uniform;
	} trial_t;

	typedef struct packed {
		logic                     accepted;
		logic                     new_spin;
		logic signed [DE_W-1:0]   energy_delta;
		logic signed [EACC_W-1:0] energy_change;
		logic signed [MAG_W-1:0]  mag_change;
		logic                     site_error;
	} outcome_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [SITE_W-1:0]        site = '0;
	logic [UNI_W-1:0]         uniform = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     accepted;
	logic                     new_spin;
	logic signed [DE_W-1:0]   energy_delta;
	logic signed [EACC_W-1:0] energy_change;
	logic signed [MAG_W-1:0]  mag_change;
	logic                     site_error;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [PADDR_W-1:0]       paddr = '0;
	logic [PDATA_W-1:0]       pwdata = '0;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;

	// shadow of the lattice, accumulators and registers
	bit                  spins [STORE_DEPTH] = '{default: 1'b1};
	logic [EACC_W-1:0]   energy_sum = '0;
	logic [MAG_W-1:0]    mag_sum = '0;
	logic [THR_W-1:0]    thr_cfg [5] = '{default: '0};
	logic signed [15:0]  j_cfg = 16'sd256;
	logic signed [15:0]  h_cfg = 16'sd0;
	logic [8:0]          side_cfg = 9'd16;

	trial_t      trial_queue [$];
	outcome_t    pending_outcomes [$];
	logic        in_took = 1'b0;
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          errors = 0;
	int unsigned cycle_count = 0;

	ising_metropolis_spin_flip dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.site          (site),
		.uniform       (uniform),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.accepted      (accepted),
		.new_spin      (new_spin),
		.energy_delta  (energy_delta),
		.energy_change (energy_change),
		.mag_change    (mag_change),
		.site_error    (site_error),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one Metropolis trial on the shadow lattice
	function automatic outcome_t metropolis_step(trial_t t);
		int unsigned side_use, vol, row, col;
		int unsigned nbr [4];
		int          nsum;
		int          spin_now;
		longint      de;
		logic [31:0] thr;
		logic        flip;
		outcome_t    r;
		side_use = (side_cfg > MAX_SIDE) ? MAX_SIDE : side_cfg;
		vol = side_use * side_use;
		r = '0;
		if (t.site >= vol) begin
			r.energy_change = energy_sum;
			r.mag_change = mag_sum;
			r.site_error = 1'b1;
			return r;
		end
		row = t.site / side_use;
		col = t.site % side_use;
		// right, up, left, down with wrap-around
		nbr[0] = row * side_use + (col + 1) % side_use;
		nbr[1] = (t.site + vol - side_use) % vol;
		nbr[2] = row * side_use + (col + side_use - 1) % side_use;
		nbr[3] = (t.site + side_use) % vol;
		nsum = 0;
		foreach (nbr[i])
			nsum += spins[nbr[i]] ? 1 : -1;
		spin_now = spins[t.site] ? 1 : -1;
		de = 2 * spin_now * (longint'(j_cfg) * nsum + longint'(h_cfg));
		thr = (spin_now > 0) ? thr_cfg[(nsum + 4) / 2][63:32] : thr_cfg[(nsum + 4) / 2][31:0];
		flip = (de < 0) || (t.uniform < thr);
		if (flip) begin
			spins[t.site] = ~spins[t.site];
			mag_sum = spins[t.site] ? mag_sum + 18'd2 : mag_sum - 18'd2;
			energy_sum = energy_sum + de[EACC_W-1:0];
		end
		r.accepted = flip;
		r.new_spin = spins[t.site];
		r.energy_delta = de[DE_W-1:0];
		r.energy_change = energy_sum;
		r.mag_change = mag_sum;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (errors < MAX_PRINTS)
			$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// word source: new word once the last one has gone, random gaps
	always @(negedge clk) begin
		trial_t nxt;
		if (!in_valid || in_took) begin
			if (arst_n && trial_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				nxt = trial_queue.pop_front();
				in_valid <= 1'b1;
				site <= nxt.site;
				uniform <= nxt.uniform;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result check and prediction at the rising edge
	always @(posedge clk) begin
		outcome_t want;
		cycle_count++;
		in_took <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("result with none expected", 0, 0);
				end else begin
					want = pending_outcomes.pop_front();
					if (accepted !== want.accepted)
						report_mismatch("accepted", accepted, want.accepted);
					if (new_spin !== want.new_spin)
						report_mismatch("new_spin", new_spin, want.new_spin);
					if (energy_delta !== want.energy_delta)
						report_mismatch("energy_delta", energy_delta, want.energy_delta);
					if (energy_change !== want.energy_change)
						report_mismatch("energy_change", energy_change, want.energy_change);
					if (mag_change !== want.mag_change)
						report_mismatch("mag_change", mag_change, want.mag_change);
					if (site_error !== want.site_error)
						report_mismatch("site_error", site_error, want.site_error);
				end
			end
			if (in_valid && in_ready)
				pending_outcomes.push_back(metropolis_step({site, uniform}));
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// register write: setup then access, shadow updated at the write edge
	task automatic write_reg(cfg_reg_t r, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (r)
			REG_COUPLING: j_cfg = value[15:0];
			REG_FIELD:    h_cfg = value[15:0];
			REG_SIDE:     side_cfg = value[8:0];
			default:      thr_cfg[r] = value;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic offer(logic [SITE_W-1:0] s, logic [UNI_W-1:0] u);
		trial_queue.push_back({s, u});
	endtask

	// everything sent and every result back; checked at the rising edge,
	// where the driven word has settled
	task automatic wait_quiet();
		while (trial_queue.size() != 0 || in_valid || pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word32();
		case ($urandom_range(5))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic set_thresholds(logic [63:0] value);
		for (int k = 0; k < 5; k++)
			write_reg(cfg_reg_t'(REG_THR_M4 + k), value);
	endtask

	task automatic set_side(int unsigned s);
		wait_quiet();
		write_reg(REG_SIDE, 64'(s));
	endtask

	initial begin
		int unsigned side_use, vol;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_gap_pct = 29;
		recv_stall_pct = 74;

		// plain lattice, flips both ways, bad sites at both ends of the range
		set_thresholds({32'h8000_0000, 32'h4000_0000});
		write_reg(REG_COUPLING, 64'd256);
		write_reg(REG_FIELD, 64'd0);
		write_reg(REG_SIDE, 64'd4);
		offer(16'd0, 32'h0);
		offer(16'd0, 32'h0);
		offer(16'd5, 32'hFFFF_FFFF);
		offer(16'd15, 32'h7FFF_FFFF);
		offer(16'd15, 32'h8000_0000);
		offer(16'd16, 32'h0);
		offer(16'd65535, 32'hFFFF_FFFF);
		wait_quiet();

		// zero energy change: only the threshold decides
		write_reg(REG_COUPLING, 64'd0);
		set_thresholds(64'h0);
		offer(16'd2, 32'h0);
		wait_quiet();
		write_reg(REG_THR_P4, 64'hFFFF_FFFF_0000_0001);
		offer(16'd9, 32'hFFFF_FFFF);
		offer(16'd9, 32'hFFFF_FFFE);
		wait_quiet();

		// coupling and field at their extremes
		set_thresholds(64'h0);
		write_reg(REG_COUPLING, 64'h8000);
		write_reg(REG_FIELD, 64'h8000);
		write_reg(REG_SIDE, 64'd2);
		offer(16'd0, 32'h0);
		offer(16'd3, 32'hFFFF_FFFF);
		offer(16'd4, 32'h0);
		wait_quiet();
		write_reg(REG_COUPLING, 64'h7FFF);
		write_reg(REG_FIELD, 64'h7FFF);
		offer(16'd1, 32'h0);
		offer(16'd2, 32'h1234_5678);
		offer(16'd0, 32'hFFFF_FFFF);

		// odd geometries: single site, empty lattice, odd side, oversize side
		set_side(1);
		offer(16'd0, 32'h0);
		offer(16'd1, 32'h0);
		set_side(0);
		offer(16'd0, 32'h0);
		set_side(3);
		offer(16'd8, 32'h0);
		offer(16'd4, 32'hFFFF_FFFF);
		set_side(511);
		offer(16'd65535, 32'h0);
		offer(16'd256, 32'hFFFF_FFFF);
		wait_quiet();

		// random phases, fresh registers each time
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				send_gap_pct = 74;
				recv_stall_pct = 29;
			end else if (ph == 8) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			for (int k = 0; k < 5; k++)
				write_reg(cfg_reg_t'(REG_THR_M4 + k), {pick_word32(), pick_word32()});
			case ($urandom_range(3))
				0:       write_reg(REG_COUPLING, 64'h8000);
				1:       write_reg(REG_COUPLING, 64'h7FFF);
				default: write_reg(REG_COUPLING, 64'($urandom_range(16'hFFFF)));
			endcase
			if ($urandom_range(1))
				write_reg(REG_FIELD, 64'($urandom_range(16'hFFFF)));
			else
				write_reg(REG_FIELD, 64'(16'($urandom_range(1024) - 512)));
			side_use = (ph == 11) ? 256 : 2 * $urandom_range(1, 8);
			write_reg(REG_SIDE, 64'(side_use));
			vol = side_use * side_use;
			// mostly in-lattice trials, the odd stray index
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(99) < 12)
					offer(16'($urandom), pick_word32());
				else
					offer(16'($urandom_range(vol - 1)), pick_word32());
			end
			wait_quiet();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ims_pkg.sv
rtl/ims_colpos.sv
rtl/ising_metropolis_spin_flip.sv
tb/tb_ising_metropolis_spin_flip.sv
